/* hdl/n2w_pkg.sv */
// Package for the number-to-word token block: token codes, microcode word
// layout and the microcode program. No dependencies.
package n2w_pkg;

  localparam int NUM_W    = 40;   // input number width
  localparam int WORD_W   = 5;    // token code width
  localparam int DIGIT_W  = 4;    // one BCD digit
  localparam int GROUP_W  = 12;   // three BCD digits
  localparam int PC_W     = 4;

  localparam logic [WORD_W-1:0] WORD_NONE      = 5'd0;
  localparam logic [WORD_W-1:0] WORD_TEEN_BASE = 5'd10;  // tens digit one: 10 + ones
  localparam logic [WORD_W-1:0] WORD_TENS_BASE = 5'd18;  // tens digit t: 18 + t
  localparam logic [WORD_W-1:0] WORD_HUNDRED   = 5'd28;  // scale of group g: 28 + g

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RANGE,
    OP_DABBLE,
    OP_HUND,
    OP_HWORD,
    OP_TENS,
    OP_ONES,
    OP_SCALE,
    OP_NEXTG
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_SPECIAL,
    COND_NOT_DONE,
    COND_GRP_ZERO,
    COND_LAST_GRP
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctrl_word_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_LOAD   = 4'd0;
  localparam logic [PC_W-1:0] PC_RANGE  = 4'd1;
  localparam logic [PC_W-1:0] PC_DABBLE = 4'd2;
  localparam logic [PC_W-1:0] PC_GRPCHK = 4'd3;
  localparam logic [PC_W-1:0] PC_HUND   = 4'd4;
  localparam logic [PC_W-1:0] PC_HWORD  = 4'd5;
  localparam logic [PC_W-1:0] PC_TENS   = 4'd6;
  localparam logic [PC_W-1:0] PC_ONES   = 4'd7;
  localparam logic [PC_W-1:0] PC_SCALE  = 4'd8;
  localparam logic [PC_W-1:0] PC_ENDCHK = 4'd9;
  localparam logic [PC_W-1:0] PC_NEXTG  = 4'd10;

  // Microcode ROM: on a true condition jump to target, else fall through.
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_LOAD};
    unique case (pc)
      PC_LOAD:   w = '{op: OP_LOAD,   cond: COND_NEVER,    target: PC_LOAD};
      PC_RANGE:  w = '{op: OP_RANGE,  cond: COND_SPECIAL,  target: PC_LOAD};
      PC_DABBLE: w = '{op: OP_DABBLE, cond: COND_NOT_DONE, target: PC_DABBLE};
      PC_GRPCHK: w = '{op: OP_NOP,    cond: COND_GRP_ZERO, target: PC_ENDCHK};
      PC_HUND:   w = '{op: OP_HUND,   cond: COND_NEVER,    target: PC_LOAD};
      PC_HWORD:  w = '{op: OP_HWORD,  cond: COND_NEVER,    target: PC_LOAD};
      PC_TENS:   w = '{op: OP_TENS,   cond: COND_NEVER,    target: PC_LOAD};
      PC_ONES:   w = '{op: OP_ONES,   cond: COND_NEVER,    target: PC_LOAD};
      PC_SCALE:  w = '{op: OP_SCALE,  cond: COND_NEVER,    target: PC_LOAD};
      PC_ENDCHK: w = '{op: OP_NOP,    cond: COND_LAST_GRP, target: PC_LOAD};
      PC_NEXTG:  w = '{op: OP_NEXTG,  cond: COND_ALWAYS,   target: PC_GRPCHK};
      default:   w = '{op: OP_NOP,    cond: COND_ALWAYS,   target: PC_LOAD};
    endcase
    return w;
  endfunction

  // 1000^g, evaluated at elaboration
  function automatic logic [63:0] pow1000(input int g);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < g; i++) begin
      p = p * 64'd1000;
    end
    return p;
  endfunction

endpackage

/* hdl/number_to_word_tokens.sv */
// Number-to-word token block: spells an unsigned number as English word
// tokens. Microcoded sequencer over a double-dabble BCD datapath.
// Depends on n2w_pkg.
//
// Input stream (in_*): one word per number, in_tdata[39:0] = number.
// Output stream (out_*): one word per token, out_tdata[4:0] = token code
// (0 none, 1-19 One..Nineteen, 20-27 Twenty..Ninety, 28 Hundred,
// 29 Thousand, 30 Million, 31 Billion); out_tlast marks a number's final
// token, out_tuser flags a number above 1000^GROUPS - 1. Zero and
// out-of-range numbers give one token of code 0 with tlast set.
// Sequence: an eleven-step ROM program runs each number, one number at a time.
// Load and range check come first; zero and out-of-range numbers end there.
// Otherwise the BCD conversion shifts the number in one bit per cycle, then
// each group from the top down is skipped when zero, else runs the hundreds
// digit, Hundred, tens, ones and scale steps; the end check stops after units.
// in_tready is high only while the program sits at its load step.
// Stall: a token waits in the output register and the sequencer holds its step
// until the register frees up; the last token may wait while the next loads.
// Reset: rst_n (synchronous, active low) returns the program to its load step
// and empties the output register.
module number_to_word_tokens #(
  parameter int GROUPS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [39:0] in_tdata,   // [39:0] number
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [4:0] word, [7:5] zero
  output logic       out_tlast,
  output logic       out_tuser    // [0] out_of_range
);
  import n2w_pkg::*;

  // No scale word above Billion: keep group count in 1..4
  localparam int GROUPS_C = (GROUPS < 1) ? 1 : ((GROUPS > 4) ? 4 : GROUPS);
  localparam int GW       = (GROUPS_C > 1) ? $clog2(GROUPS_C) : 1;
  localparam int BCD_W    = GROUP_W * GROUPS_C;
  localparam int NDIG     = 3 * GROUPS_C;
  localparam int CNT_W    = $clog2(NUM_W);
  localparam logic [63:0] LIMIT = pow1000(GROUPS_C);

  // Sequencer state
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [GW-1:0]     g_r, g_nxt;
  logic              zero_r, zero_nxt;
  logic              oor_r, oor_nxt;
  // Datapath
  logic [NUM_W-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_oor_r, out_oor_nxt;

  ctrl_word_t        cw;
  logic              cond_true;
  logic              in_acc;
  logic              out_free;
  logic              emit_want;
  logic              emit_last;
  logic [WORD_W-1:0] emit_word;
  logic              emit_oor;
  logic              hold;
  logic [GROUP_W-1:0] grp;
  logic [DIGIT_W-1:0] hund, tens, ones;
  logic [GROUPS_C-1:0] grp_nz;
  logic              lower_nz;
  logic [BCD_W-1:0]  bcd_adj;

  assign cw        = ucode_rom(pc_r);
  assign in_tready = (cw.op == OP_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign grp  = bcd_r[g_r*GROUP_W +: GROUP_W];
  assign hund = grp[11:8];
  assign tens = grp[7:4];
  assign ones = grp[3:0];

  // Nonzero flags of each group; any nonzero group below the current one
  always_comb begin
    lower_nz = 1'b0;
    for (int i = 0; i < GROUPS_C; i++) begin
      grp_nz[i] = |bcd_r[i*GROUP_W +: GROUP_W];
      if (i < int'(g_r) && grp_nz[i]) begin
        lower_nz = 1'b1;
      end
    end
  end

  // Double-dabble adjust: add three to every digit of five or more
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Token of the current step; last when nothing follows in this group or below
  always_comb begin
    emit_want = 1'b0;
    emit_word = WORD_NONE;
    emit_last = 1'b0;
    emit_oor  = 1'b0;
    unique case (cw.op)
      OP_RANGE: begin
        emit_want = zero_r || oor_r;
        emit_last = 1'b1;
        emit_oor  = oor_r;
      end
      OP_HUND: begin
        emit_want = (hund != '0);
        emit_word = WORD_W'(hund);
      end
      OP_HWORD: begin
        emit_want = (hund != '0);
        emit_word = WORD_HUNDRED;
        emit_last = !((tens != '0) || (ones != '0) || (g_r != '0)) && !lower_nz;
      end
      OP_TENS: begin
        emit_want = (tens != '0) || (ones != '0);
        if (tens == 4'd0) begin
          emit_word = WORD_W'(ones);
        end else if (tens == 4'd1) begin
          emit_word = WORD_TEEN_BASE + WORD_W'(ones);
        end else begin
          emit_word = WORD_TENS_BASE + WORD_W'(tens);
        end
        emit_last = !((tens >= 4'd2 && ones != '0) || (g_r != '0)) && !lower_nz;
      end
      OP_ONES: begin
        emit_want = (tens >= 4'd2) && (ones != '0);
        emit_word = WORD_W'(ones);
        emit_last = (g_r == '0) && !lower_nz;
      end
      OP_SCALE: begin
        emit_want = (g_r != '0);
        emit_word = WORD_HUNDRED + WORD_W'(g_r);
        emit_last = !lower_nz;
      end
      default: begin
        emit_want = 1'b0;
      end
    endcase
  end

  // Branch condition
  always_comb begin
    unique case (cw.cond)
      COND_NEVER:    cond_true = 1'b0;
      COND_ALWAYS:   cond_true = 1'b1;
      COND_SPECIAL:  cond_true = zero_r || oor_r;
      COND_NOT_DONE: cond_true = (cnt_r != CNT_W'(NUM_W - 1));
      COND_GRP_ZERO: cond_true = (grp == '0);
      COND_LAST_GRP: cond_true = (g_r == '0);
      default:       cond_true = 1'b0;
    endcase
  end

  // Hold the step while waiting for an input word or for room at the output
  assign hold = ((cw.op == OP_LOAD) && !in_acc) || (emit_want && !out_free);

  always_comb begin
    pc_nxt        = pc_r;
    cnt_nxt       = cnt_r;
    g_nxt         = g_r;
    zero_nxt      = zero_r;
    oor_nxt       = oor_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    out_oor_nxt   = out_oor_r;

    if (!hold) begin
      pc_nxt = cond_true ? cw.target : pc_r + PC_W'(1);
      unique case (cw.op)
        OP_LOAD: begin
          bin_nxt  = in_tdata;
          bcd_nxt  = '0;
          cnt_nxt  = '0;
          g_nxt    = GW'(GROUPS_C - 1);
          zero_nxt = (in_tdata == '0);
          oor_nxt  = ({24'd0, in_tdata} >= LIMIT);
        end
        OP_DABBLE: begin
          bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[NUM_W-1]};
          bin_nxt = {bin_r[NUM_W-2:0], 1'b0};
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        OP_NEXTG: begin
          g_nxt = g_r - GW'(1);
        end
        default: begin
          g_nxt = g_r;
        end
      endcase
      if (emit_want) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = emit_word;
        out_last_nxt  = emit_last;
        out_oor_nxt   = emit_oor;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    g_r        <= g_nxt;
    zero_r     <= zero_nxt;
    oor_r      <= oor_nxt;
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_word_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_oor_r;

endmodule

/* tb/tb_number_to_word_tokens.sv */
// Self-checking testbench for number_to_word_tokens: drives numbers on the input stream,
// predicts the English word tokens of each one and checks every output token in order.
// Depends on n2w_pkg and the number_to_word_tokens RTL.
module tb_number_to_word_tokens;
  import n2w_pkg::*;

  // Largest number that the block spells with four three-digit groups
  localparam logic [63:0] MAX_SPELLABLE = 64'd999_999_999_999;
  // Width of the random range above MAX_SPELLABLE: 2^40 - 10^12
  localparam logic [63:0] OVER_SPAN     = 64'd99_511_627_776;
  localparam int          CYCLE_LIMIT   = 1_200_000;
  localparam int          TAIL_CYCLES   = 100;   // past the longest program run
  localparam int          RANDOM_ITEMS  = 360;

  typedef struct packed {
    logic [WORD_W-1:0] code;
    logic              last;
    logic              oor;
  } token_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,        // always ready
    RX_COIN,        // ready half the time
    RX_MOSTLY,      // ready three quarters of the time
    RX_LONG_STALL   // ready, with occasional long stalls
  } rx_mode_t;

  // Kinds of random number
  typedef enum logic [2:0] {
    NUM_GROUPED,    // built group by group, some groups zero
    NUM_ANY,        // any 40-bit value
    NUM_BELOW_1000,
    NUM_OVER,       // above the spellable range
    NUM_ZERO
  } num_kind_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [NUM_W-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              out_tlast;
  logic              out_tuser;

  token_t expected_tokens[$];

  int       error_count = 0;
  int       cycle_count = 0;
  int       numbers_sent = 0;
  int       numbers_over = 0;
  int       numbers_zero = 0;
  int       tokens_checked = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_phase_left = 0;
  int       rx_stall_left = 0;

  number_to_word_tokens u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [39:0] number
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [4:0] word, [7:5] zero
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)    // [0] out_of_range
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d tokens still expected", $time, expected_tokens.size());
      $display("[number_to_word_tokens] ERROR");
      $finish;
    end
  end

  // Append the tokens that spell one number, in reading order.
  function automatic void spell_number(input logic [NUM_W-1:0] num);
    logic [63:0]       value;
    logic [63:0]       weight;
    logic [63:0]       grp;
    logic [63:0]       rest;
    logic [WORD_W-1:0] codes [0:18];
    int                cnt;
    token_t            tok;
    value  = num;
    weight = 64'd1_000_000_000;
    cnt    = 0;
    // Zero and too-large numbers give one empty token; only the latter is flagged
    if (value == 0 || value > MAX_SPELLABLE) begin
      tok.code = WORD_NONE;
      tok.last = 1'b1;
      tok.oor  = (value != 0);
      expected_tokens.push_back(tok);
      return;
    end
    // Walk groups from billions down to units; zero groups say nothing
    for (int g = 3; g >= 0; g--) begin
      grp  = (value / weight) % 1000;
      rest = grp % 100;
      if (grp != 0) begin
        if (grp >= 100) begin
          codes[cnt]     = WORD_W'(grp / 100);
          codes[cnt + 1] = WORD_HUNDRED;
          cnt += 2;
        end
        if (rest >= 1 && rest <= 19) begin
          codes[cnt] = WORD_W'(rest);
          cnt++;
        end else if (rest >= 20) begin
          codes[cnt] = WORD_TENS_BASE + WORD_W'(rest / 10);
          cnt++;
          if (rest % 10 != 0) begin
            codes[cnt] = WORD_W'(rest % 10);
            cnt++;
          end
        end
        // Thousand, Million, Billion follow Hundred in code order
        if (g > 0) begin
          codes[cnt] = WORD_HUNDRED + WORD_W'(g);
          cnt++;
        end
      end
      weight = weight / 1000;
    end
    for (int i = 0; i < cnt; i++) begin
      tok.code = codes[i];
      tok.last = (i == cnt - 1);
      tok.oor  = 1'b0;
      expected_tokens.push_back(tok);
    end
  endfunction

  // Send one number: insert a random gap between bursts, then hold the word
  // until the block takes it.
  task automatic send_number(input logic [63:0] num);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 90);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 12);
    end
    in_tvalid = 1'b1;
    in_tdata  = num[NUM_W-1:0];
    do @(posedge clk); while (!in_tready);
    spell_number(num[NUM_W-1:0]);
    numbers_sent++;
    if (num == 0) numbers_zero++;
    if (num > MAX_SPELLABLE) numbers_over++;
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Wait until every expected token has come out.
  task automatic drain_tokens();
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  // Receiver: pick a new random stall pattern at the end of each random-length phase.
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       = rx_mode_t'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(50, 400);
    end else begin
      rx_phase_left--;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(5, 30);
        end
      end
    endcase
  end

  // Check each accepted token against the oldest expectation.
  always @(posedge clk) begin : check_token
    token_t exp_tok;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tokens.size() == 0) begin
        error_count++;
        $display("%0t: unexpected token, expected none, got data %0d last %0b oor %0b",
                 $time, out_tdata, out_tlast, out_tuser);
      end else begin
        exp_tok = expected_tokens.pop_front();
        tokens_checked++;
        if (out_tdata !== {3'b000, exp_tok.code}) begin
          error_count++;
          $display("%0t: token data mismatch, expected %0d, got %0d",
                   $time, exp_tok.code, out_tdata);
        end
        if (out_tlast !== exp_tok.last) begin
          error_count++;
          $display("%0t: tlast mismatch, expected %0b, got %0b",
                   $time, exp_tok.last, out_tlast);
        end
        if (out_tuser !== exp_tok.oor) begin
          error_count++;
          $display("%0t: out_of_range mismatch, expected %0b, got %0b",
                   $time, exp_tok.oor, out_tuser);
        end
      end
    end
  end

  // Zero, range edges, out-of-range edges and the longest run.
  task automatic test_boundaries();
    send_number(64'd0);
    send_number(64'd1);
    send_number(MAX_SPELLABLE);                 // nineteen tokens
    send_number(64'd1_000_000_000_000);         // first out-of-range value
    send_number(64'hFF_FFFF_FFFF);              // all ones
    send_number(64'd1_000_000_000);
  endtask

  // Teens, tens with and without ones, hundreds, and zero groups in between.
  task automatic test_word_forms();
    send_number(64'd13);
    send_number(64'd19);
    send_number(64'd20);
    send_number(64'd21);
    send_number(64'd99);
    send_number(64'd100);
    send_number(64'd101);
    send_number(64'd110);
    send_number(64'd1000);
    send_number(64'd1001);
    send_number(64'd1_000_000);
    send_number(64'd512_000_000);
    send_number(64'd1_010_101);
    send_number(64'd900_000_090);
    send_number(64'd777_017_000_013);
    send_number(64'd100_000_000_000);
    send_number(64'd40_060_080_050);
  endtask

  // Mostly well-formed group patterns, with raw 40-bit values and edges mixed in.
  task automatic test_random_numbers(input int count);
    num_kind_t   kind;
    logic [63:0] num;
    logic [63:0] grp;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 60) ? NUM_GROUPED :
             (pick < 75) ? NUM_ANY :
             (pick < 85) ? NUM_BELOW_1000 :
             (pick < 95) ? NUM_OVER : NUM_ZERO;
      case (kind)
        NUM_GROUPED: begin
          num = 0;
          // Leave some groups zero; bias toward sparse groups
          for (int g = 0; g < 4; g++) begin
            grp = ($urandom_range(0, 3) == 0) ? 0 :
                  ($urandom_range(0, 2) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 999);
            num = num * 1000 + grp;
          end
        end
        NUM_ANY:        num = {$urandom, $urandom} & 64'hFF_FFFF_FFFF;
        NUM_BELOW_1000: num = $urandom_range(0, 999);
        NUM_OVER:       num = MAX_SPELLABLE + 1 + ({$urandom, $urandom} % OVER_SPAN);
        default:        num = 0;
      endcase
      send_number(num);
    end
  endtask

  // Hold off the sender until the block has emptied, then resume.
  task automatic test_drain_and_resume();
    drain_tokens();
    repeat ($urandom_range(1, 40)) @(negedge clk);
    send_number(64'd21_000_019);
    send_number(64'd0);
  endtask

  initial begin
    // Hold reset, then release it at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_boundaries();
    test_word_forms();
    test_random_numbers(RANDOM_ITEMS / 2);
    test_drain_and_resume();
    test_random_numbers(RANDOM_ITEMS / 2);

    // Drain, then give the block time to emit anything stray
    drain_tokens();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_tokens.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected tokens never arrived", $time, expected_tokens.size());
    end
    $display("Spelled %0d numbers (%0d zero, %0d out of range) as %0d checked tokens,",
             numbers_sent, numbers_zero, numbers_over, tokens_checked);
    $display("under bursty input and four receiver stall patterns.");
    if (error_count == 0) begin
      $display("[number_to_word_tokens] OK");
    end else begin
      $display("[number_to_word_tokens] ERROR");
    end
    $finish;
  end

endmodule

/* number_to_word_tokens.f */
hdl/n2w_pkg.sv
hdl/number_to_word_tokens.sv
tb/tb_number_to_word_tokens.sv
